FILE: rtl/setq_pkg.sv
// Shared types, constants and command codes for the sorted event timer queue.
// No dependencies; imported by every module of the block.
package setq_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int KEY_W = 16;
    localparam int FUNC_W = 3;
    localparam int DIST_W = 33;
    localparam int RCNT_W = 5;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 3'd0,
        FN_START  = 3'd1,
        FN_PAUSE  = 3'd2,
        FN_STOP   = 3'd3,
        FN_ADD    = 3'd4,
        FN_RMNEXT = 3'd5,
        FN_RMALL  = 3'd6,
        FN_TTE    = 3'd7
    } func_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Commands from controller to datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture input beat, clear result fields
        OP_DIV_START, // start modulo unit on dividend selected by dsel
        OP_DIV_STEP,
        OP_TICK_EXEC, // apply tick using reduced now / next
        OP_TIMER,     // start, pause or stop
        OP_ADD_EXEC,  // halt timer, reset read pointer, start insert scan at table end
        OP_SCAN,      // examine entry at scan pointer
        OP_SHIFT,     // move entry scan+1 down to scan
        OP_SHIFT_UP,  // move entry scan-1 up to scan
        OP_FINISH     // final distance / status
    } op_t;

    typedef enum logic [1:0] {
        DSEL_ELAPSED,
        DSEL_ELAPSED_INC,
        DSEL_TIN,
        DSEL_ENTRY
    } dsel_t;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
    } setq_cmd_t;

    typedef struct packed {
        logic  div_done;
        logic  periodic;
        logic  scan_end;   // scan pointer past the last valid entry
        logic  shift_last; // removal shift pass is at its last step
        logic  full;
        logic  found;
        logic  ins_here;   // add: shifting reached insert position
        logic  search_done;
        func_t func;
    } setq_stat_t;
endpackage

FILE: rtl/setq_moddiv.sv
// Restoring bit-serial modulo unit, one quotient bit per cycle.
// Depends on setq_pkg.
module setq_moddiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [setq_pkg::TIME_W:0] dividend,
    input  logic [setq_pkg::TIME_W-1:0] divisor,
    output logic                      done,
    output logic [setq_pkg::TIME_W-1:0] remainder
);
    import setq_pkg::*;
    localparam int DW = TIME_W + 1;

    logic [DW-1:0]        num_reg;
    logic [DW:0]          rem_reg;
    logic [$clog2(DW+1)-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DW:0]          trial;

    assign trial = {rem_reg[DW-1:0], num_reg[DW-1]} - {2'b0, divisor};
    assign done = !busy_reg;
    assign remainder = rem_reg[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= ($clog2(DW+1))'(DW);
            num_reg  <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            if (!trial[DW]) begin
                rem_reg <= trial;
            end else begin
                rem_reg <= {rem_reg[DW-1:0], num_reg[DW-1]};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 1) begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/setq_datapath.sv
// Datapath: event table, timer registers, scan pointer and result register.
// Depends on setq_pkg and setq_moddiv.
module setq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  setq_pkg::setq_cmd_t           cmd,
    output setq_pkg::setq_stat_t          stat,
    input  logic [setq_pkg::TIME_W-1:0]   cfg_wdata,
    input  logic                          cfg_wen,
    input  logic [setq_pkg::IN_TDATA_W-1:0] in_data,
    output logic [setq_pkg::OUT_TDATA_W-1:0] out_data
);
    import setq_pkg::*;

    logic [TIME_W-1:0] tbl_time [TABLE_DEPTH];
    logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];

    logic [TIME_W-1:0] period_reg, elapsed_reg, last_reg, now_reg, t_reg;
    logic [CNT_W-1:0]  count_reg, rptr_reg, scan_reg, start_reg;
    logic              running_reg, paused_reg;
    func_t             func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] tin_reg;
    logic              found_reg, search_reg, wrapped_reg;

    logic              fired_reg;
    logic [KEY_W-1:0]  fkey_reg;
    logic [1:0]        status_reg;
    logic [RCNT_W-1:0] removed_reg;
    logic [DIST_W-1:0] dist_reg;

    logic              div_start, div_done;
    logic [TIME_W:0]   div_num;
    logic [TIME_W-1:0] div_rem;
    logic              periodic;
    logic [IDX_W-1:0]  sidx, sidx_p1, sidx_m1;
    logic              in_range;
    logic              shift_last;
    logic              advance;
    logic [TIME_W-1:0] tick_now;

    assign periodic   = (period_reg != '0);
    assign sidx       = scan_reg[IDX_W-1:0];
    assign sidx_p1    = IDX_W'(scan_reg + 1'b1);
    assign sidx_m1    = IDX_W'(scan_reg - 1'b1);
    assign in_range   = (scan_reg < count_reg);
    assign shift_last = (CNT_W'(scan_reg + 1'b1) >= count_reg);
    assign advance    = running_reg && !paused_reg;

    // Time seen by a tick: periodic ticks arrive with now_reg already reduced
    // (and advanced when running and not paused); one-shot ticks saturate at the top count.
    always_comb begin
        if (periodic) begin
            tick_now = now_reg;
        end else if (advance && elapsed_reg != '1) begin
            tick_now = elapsed_reg + 1'b1;
        end else begin
            tick_now = elapsed_reg;
        end
    end

    always_comb begin
        case (cmd.dsel)
            DSEL_ELAPSED:     div_num = {1'b0, elapsed_reg};
            DSEL_ELAPSED_INC: div_num = {1'b0, now_reg} + 1'b1;
            DSEL_TIN:         div_num = {1'b0, tin_reg};
            default:          div_num = {1'b0, tbl_time[sidx]};
        endcase
    end
    assign div_start = (cmd.op == OP_DIV_START);

    setq_moddiv u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(period_reg), .done(div_done), .remainder(div_rem)
    );

    assign stat.div_done    = div_done && !div_start;
    assign stat.periodic    = periodic;
    assign stat.scan_end    = !in_range;
    assign stat.shift_last  = shift_last;
    assign stat.full        = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign stat.found       = found_reg;
    assign stat.ins_here    = (scan_reg == '0) || (tbl_time[sidx_m1] <= t_reg);
    assign stat.search_done = search_reg;
    assign stat.func        = func_reg;

    assign out_data = {{(OUT_TDATA_W-57){1'b0}}, dist_reg, removed_reg, status_reg,
                       fkey_reg, fired_reg};

    // Distance for time to event; t_reg holds the entry time reduced.
    logic [TIME_W:0] back, fwd, back_raw;
    always_comb begin
        back_raw = {1'b0, now_reg} + {1'b0, period_reg} - {1'b0, t_reg};
        back = (back_raw >= {1'b0, period_reg}) ? back_raw - {1'b0, period_reg}
                                                : back_raw;
        fwd  = {1'b0, period_reg} - back;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= '0;
            elapsed_reg <= '0;
            last_reg    <= '0;
            count_reg   <= '0;
            rptr_reg    <= '0;
            running_reg <= 1'b0;
            paused_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                period_reg <= cfg_wdata;
            end
            case (cmd.op)
                OP_LOAD: begin
                    func_reg    <= func_t'(in_data[FUNC_W-1:0]);
                    key_reg     <= in_data[FUNC_W +: KEY_W];
                    tin_reg     <= in_data[FUNC_W+KEY_W +: TIME_W];
                    fired_reg   <= 1'b0;
                    fkey_reg    <= '0;
                    status_reg  <= ST_OK;
                    removed_reg <= '0;
                    dist_reg    <= '0;
                    scan_reg    <= '0;
                    found_reg   <= 1'b0;
                    search_reg  <= 1'b0;
                    wrapped_reg <= 1'b0;
                    now_reg     <= elapsed_reg;
                    t_reg       <= in_data[FUNC_W+KEY_W +: TIME_W];
                end
                OP_DIV_START: ;
                OP_DIV_STEP: begin
                    if (div_done) begin
                        if (cmd.dsel == DSEL_ENTRY || cmd.dsel == DSEL_TIN) begin
                            t_reg <= div_rem;
                        end else if (cmd.dsel == DSEL_ELAPSED || advance) begin
                            // A stopped or paused timer keeps the reduced now.
                            now_reg <= div_rem;
                        end
                    end
                end
                OP_TICK_EXEC: begin
                    if (advance) begin
                        elapsed_reg <= tick_now;
                    end
                    if (count_reg != '0) begin
                        if (rptr_reg >= count_reg) begin
                            if (periodic && tick_now < last_reg) begin
                                rptr_reg <= '0;
                            end
                        end else if (tbl_time[rptr_reg[IDX_W-1:0]] <= tick_now) begin
                            fired_reg <= 1'b1;
                            fkey_reg  <= tbl_key[rptr_reg[IDX_W-1:0]];
                            rptr_reg  <= rptr_reg + 1'b1;
                        end
                        last_reg <= tick_now;
                    end
                end
                OP_TIMER: begin
                    case (func_reg)
                        FN_START: begin
                            if (!paused_reg) elapsed_reg <= '0;
                            paused_reg  <= 1'b0;
                            running_reg <= 1'b1;
                        end
                        FN_PAUSE: paused_reg <= 1'b1;
                        default: begin
                            running_reg <= 1'b0;
                            paused_reg  <= 1'b0;
                            elapsed_reg <= '0;
                        end
                    endcase
                end
                OP_SHIFT_UP: begin
                    // Add: scan_reg walks down from count; opens a slot.
                    if (scan_reg == '0 || tbl_time[sidx_m1] <= t_reg) begin
                        tbl_time[sidx] <= t_reg;
                        tbl_key[sidx]  <= key_reg;
                        count_reg      <= count_reg + 1'b1;
                    end else begin
                        tbl_time[sidx] <= tbl_time[sidx_m1];
                        tbl_key[sidx]  <= tbl_key[sidx_m1];
                        scan_reg       <= scan_reg - 1'b1;
                    end
                end
                OP_ADD_EXEC: begin
                    running_reg <= 1'b0;
                    paused_reg  <= 1'b0;
                    elapsed_reg <= '0;
                    rptr_reg    <= '0;
                    scan_reg    <= count_reg;
                    if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                        status_reg <= ST_FULL;
                    end
                end
                OP_SCAN: begin
                    case (func_reg)
                        FN_RMNEXT: begin
                            if (!search_reg) begin
                                // Find start: first entry with time >= now.
                                if (in_range && tbl_time[sidx] < now_reg) begin
                                    scan_reg <= scan_reg + 1'b1;
                                end else begin
                                    search_reg <= 1'b1;
                                    start_reg  <= (periodic && !in_range) ? '0 : scan_reg;
                                    if (periodic && !in_range) scan_reg <= '0;
                                end
                            end else if (in_range && tbl_key[sidx] == key_reg) begin
                                found_reg <= 1'b1;
                                if (scan_reg < rptr_reg) rptr_reg <= rptr_reg - 1'b1;
                            end else begin
                                // Advance with wrap when periodic.
                                if (periodic && (scan_reg + 1'b1 >= count_reg)
                                    && !wrapped_reg) begin
                                    scan_reg    <= '0;
                                    wrapped_reg <= 1'b1;
                                    if (start_reg == '0) scan_reg <= count_reg;
                                end else begin
                                    scan_reg <= scan_reg + 1'b1;
                                end
                                if (wrapped_reg && scan_reg + 1'b1 >= start_reg) begin
                                    scan_reg <= count_reg;
                                end
                            end
                        end
                        FN_RMALL: begin
                            if (in_range && tbl_key[sidx] == key_reg) begin
                                // Remember where to resume after the shift pass.
                                found_reg   <= 1'b1;
                                start_reg   <= scan_reg;
                                removed_reg <= removed_reg + 1'b1;
                                if (scan_reg < rptr_reg) rptr_reg <= rptr_reg - 1'b1;
                            end else begin
                                scan_reg <= scan_reg + 1'b1;
                            end
                        end
                        default: begin
                            // Time to event: lowest matching entry.
                            if (in_range && tbl_key[sidx] == key_reg) begin
                                found_reg <= 1'b1;
                                t_reg     <= tbl_time[sidx];
                            end else begin
                                scan_reg <= scan_reg + 1'b1;
                            end
                        end
                    endcase
                end
                OP_SHIFT: begin
                    // Close the gap at scan_reg; done when reaching the end.
                    if (scan_reg + 1'b1 < count_reg) begin
                        tbl_time[sidx] <= tbl_time[sidx_p1];
                        tbl_key[sidx]  <= tbl_key[sidx_p1];
                    end
                    if (shift_last) begin
                        count_reg <= count_reg - 1'b1;
                        scan_reg  <= start_reg;
                        // Remove all resumes its scan; remove next keeps its hit.
                        if (func_reg == FN_RMALL) found_reg <= 1'b0;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                OP_FINISH: begin
                    if (func_reg == FN_TTE) begin
                        if (!found_reg) begin
                            status_reg <= ST_NOTFOUND;
                        end else if (periodic) begin
                            dist_reg <= (fwd < back) ? DIST_W'(fwd) : DIST_W'(-back);
                        end else begin
                            dist_reg <= DIST_W'({1'b0, t_reg} - {1'b0, now_reg});
                        end
                    end else if (func_reg == FN_RMNEXT && !found_reg) begin
                        status_reg <= ST_NOTFOUND;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/setq_ctrl.sv
// Controller state machine sequencing each command through the datapath.
// Depends on setq_pkg.
module setq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output setq_pkg::setq_cmd_t   cmd,
    input  setq_pkg::setq_stat_t  stat
);
    import setq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_NOW_DIV, S_INC_DIV, S_TICK, S_TIMER,
        S_TIN_DIV, S_ADD, S_INSERT, S_SCAN, S_SHIFT, S_ENT_DIV, S_FINISH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   divwait_reg, divwait_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next   = state_reg;
        divwait_next = 1'b0;
        cmd.op   = OP_NONE;
        cmd.dsel = DSEL_ELAPSED;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.func == FN_TICK || stat.func == FN_RMNEXT
                    || stat.func == FN_TTE) begin
                    if (stat.periodic) begin
                        cmd.op = OP_DIV_START;
                        state_next = S_NOW_DIV;
                    end else if (stat.func == FN_TICK) begin
                        state_next = S_TICK;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else if (stat.func == FN_ADD) begin
                    if (stat.periodic) begin
                        cmd.op = OP_DIV_START;
                        cmd.dsel = DSEL_TIN;
                        state_next = S_TIN_DIV;
                    end else begin
                        state_next = S_ADD;
                    end
                end else if (stat.func == FN_RMALL) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_TIMER;
                end
            end
            S_NOW_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_done) begin
                    state_next = (stat.func == FN_TICK) ? S_INC_DIV : S_SCAN;
                    if (stat.func == FN_TICK) divwait_next = 1'b1;
                end
            end
            S_INC_DIV: begin
                if (divwait_reg) begin
                    cmd.op = OP_DIV_START;
                    cmd.dsel = DSEL_ELAPSED_INC;
                end else begin
                    cmd.op = OP_DIV_STEP;
                    cmd.dsel = DSEL_ELAPSED_INC;
                    if (stat.div_done) state_next = S_TICK;
                end
            end
            S_TICK: begin
                cmd.op = OP_TICK_EXEC;
                state_next = S_OUT;
            end
            S_TIMER: begin
                cmd.op = OP_TIMER;
                state_next = S_OUT;
            end
            S_TIN_DIV: begin
                cmd.op = OP_DIV_STEP;
                cmd.dsel = DSEL_TIN;
                if (stat.div_done) state_next = S_ADD;
            end
            S_ADD: begin
                cmd.op = OP_ADD_EXEC;
                state_next = stat.full ? S_OUT : S_INSERT;
            end
            S_INSERT: begin
                cmd.op = OP_SHIFT_UP;
                if (stat.ins_here) state_next = S_OUT;
            end
            S_SCAN: begin
                if (stat.found) begin
                    if (stat.func == FN_TTE) begin
                        if (stat.periodic) begin
                            cmd.op = OP_DIV_START;
                            cmd.dsel = DSEL_ENTRY;
                            state_next = S_ENT_DIV;
                        end else begin
                            state_next = S_FINISH;
                        end
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else if (stat.scan_end && (stat.func != FN_RMNEXT
                                               || stat.search_done)) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.op = OP_SCAN;
                end
            end
            S_SHIFT: begin
                cmd.op = OP_SHIFT;
                if (stat.shift_last) begin
                    state_next = (stat.func == FN_RMALL) ? S_SCAN : S_FINISH;
                end
            end
            S_ENT_DIV: begin
                cmd.op = OP_DIV_STEP;
                cmd.dsel = DSEL_ENTRY;
                if (stat.div_done) state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.op = OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            divwait_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            divwait_reg <= divwait_next;
        end
    end
endmodule

FILE: rtl/sorted_event_timer_queue_core.sv
// Top level of the sorted event timer queue: controller plus datapath.
// Depends on setq_pkg, setq_ctrl and setq_datapath.
//
// Usage: each input beat on the s_ channel carries one command (tick, start,
// pause, stop, add, remove next, remove all, time to event) and yields exactly
// one result beat on the m_ channel. The user must write the period register
// through cfg_wen / cfg_wdata only while the block is idle; the block itself does
// not enforce this. Zero period selects one-shot mode. Start, pause and stop go
// from decode straight to the timer update and the result beat. A one-shot tick
// goes straight to the tick update; a periodic tick first runs the bit-serial
// modulo unit twice. Add walks the table from its end to the insert point, after
// a modulo reduction of the event time when periodic. Removals scan the table one
// entry a cycle, pausing the scan to close each gap with a shift pass.
// One command is in flight at a time; s_axis_tready is high only when idle.
// Reset (aresetn low at a clock edge) empties the table, stops the timer and
// clears the period. When the receiver stalls, the result beat holds on
// m_axis_tdata with m_axis_tvalid high until it is taken.
module sorted_event_timer_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func [2:0], event_key [18:3], event_time [50:19], zeros above
    input  logic [setq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_fired [0], fired_key [16:1], status [18:17], removed_count [23:19],
    // distance [56:24], zeros above
    output logic [setq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import setq_pkg::*;

    setq_cmd_t  cmd;
    setq_stat_t stat;

    setq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    setq_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_wdata(cfg_wdata), .cfg_wen(cfg_wen),
        .in_data(s_axis_tdata), .out_data(m_axis_tdata)
    );
endmodule

FILE: rtl/setq_checker.sv
// Port-level checker for the sorted event timer queue, bound to the top level.
// Depends on setq_pkg and sorted_event_timer_queue_core.
module setq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [setq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import setq_pkg::*;

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result before command processed");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[18:17] != 2'd3))
        else $error("illegal status code");
endmodule

bind sorted_event_timer_queue_core setq_checker u_setq_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
